@@ design/ur_string_header_parser_assert.svh @@
// assertion macros used by the ur header parser checker
`ifndef UR_STRING_HEADER_PARSER_ASSERT_SVH
`define UR_STRING_HEADER_PARSER_ASSERT_SVH

// same-cycle implication under reset
`define USHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ur header parser check failed");

// next-cycle implication under reset
`define USHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ur header parser check failed");

`endif

@@ design/ushp_pkg.sv @@
// types and constants for the ur header parser
package ushp_pkg;

    localparam int SEG_CAP    = 10;
    localparam int KEPT_W     = $clog2(SEG_CAP + 1);
    localparam int IDX_W      = 4;
    localparam int PREFIX_LEN = 3;

    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_SLASH  = 8'h2f;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2d;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0]       lower_char;
        logic             in_kept_segment;
        logic [IDX_W-1:0] segment_index;
        logic             segment_first;
        logic             done_res;
        logic             accepted;
        logic [IDX_W-1:0] seg_total;
    } result_t;

endpackage

@@ design/ushp_in_stage.sv @@
// input register for one character word
module ushp_in_stage
    import ushp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  [7:0] char_in,
    input  logic  is_last,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{ch: char_in, last: is_last};
        end
    end

endmodule

@@ design/ushp_step.sv @@
// parse state registers and per-character parse logic
module ushp_step
    import ushp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output result_t res
);

    logic [1:0]        prefix_pos_reg, prefix_pos_next;
    logic              prefix_bad_reg, prefix_bad_next;
    logic              seg_open_reg, seg_open_next;
    logic [KEPT_W-1:0] kept_count_reg, kept_count_next;
    logic              type_bad_reg, type_bad_next;
    logic              type_hyph_reg, type_hyph_next;
    logic              path_nonempty_reg, path_nonempty_next;

    logic [7:0]        c;
    logic [7:0]        want;
    logic              kept;
    logic              first;
    logic              type_ok;
    logic              accept;
    logic [KEPT_W-1:0] idx;

    always_comb
    begin
        c = item.ch;
        if (item.ch >= 8'h41 && item.ch <= 8'h5a)
        begin
            c = item.ch + 8'h20;
        end
    end

    always_comb
    begin
        unique case (prefix_pos_reg)
            2'd0:    want = CHAR_U;
            2'd1:    want = CHAR_R;
            default: want = CHAR_COLON;
        endcase
    end

    assign type_ok = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39)
                     || (c == CHAR_HYPHEN);

    always_comb
    begin
        prefix_pos_next    = prefix_pos_reg;
        prefix_bad_next    = prefix_bad_reg;
        seg_open_next      = seg_open_reg;
        kept_count_next    = kept_count_reg;
        type_bad_next      = type_bad_reg;
        type_hyph_next     = type_hyph_reg;
        path_nonempty_next = path_nonempty_reg;
        kept               = 1'b0;
        first              = 1'b0;
        idx                = '0;

        if (prefix_pos_reg != 2'(PREFIX_LEN))
        begin
            if (c != want)
            begin
                prefix_bad_next = 1'b1;
            end
            prefix_pos_next = prefix_pos_reg + 2'd1;
        end
        else
        begin
            path_nonempty_next = 1'b1;
            if (c == CHAR_SLASH)
            begin
                seg_open_next = 1'b0;
            end
            else
            begin
                if (!seg_open_reg && kept_count_reg < KEPT_W'(SEG_CAP))
                begin
                    seg_open_next   = 1'b1;
                    kept_count_next = kept_count_reg + KEPT_W'(1);
                    first           = 1'b1;
                end
                if (seg_open_next)
                begin
                    kept = 1'b1;
                    idx  = kept_count_next - KEPT_W'(1);
                    if (idx == '0)
                    begin
                        if ((first && c == CHAR_HYPHEN) || !type_ok)
                        begin
                            type_bad_next = 1'b1;
                        end
                        type_hyph_next = (c == CHAR_HYPHEN);
                    end
                end
            end
        end

        accept = item.last && (prefix_pos_next == 2'(PREFIX_LEN)) && !prefix_bad_next
                 && path_nonempty_next && (kept_count_next >= KEPT_W'(2))
                 && !type_bad_next && !type_hyph_next;

        res.lower_char      = c;
        res.in_kept_segment = kept;
        res.segment_index   = IDX_W'(idx);
        res.segment_first   = first;
        res.done_res        = item.last;
        res.accepted        = accept;
        res.seg_total       = accept ? IDX_W'(kept_count_next - KEPT_W'(1)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_pos_reg    <= '0;
            prefix_bad_reg    <= 1'b0;
            seg_open_reg      <= 1'b0;
            kept_count_reg    <= '0;
            type_bad_reg      <= 1'b0;
            type_hyph_reg     <= 1'b0;
            path_nonempty_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (item.last)
            begin
                prefix_pos_reg    <= '0;
                prefix_bad_reg    <= 1'b0;
                seg_open_reg      <= 1'b0;
                kept_count_reg    <= '0;
                type_bad_reg      <= 1'b0;
                type_hyph_reg     <= 1'b0;
                path_nonempty_reg <= 1'b0;
            end
            else
            begin
                prefix_pos_reg    <= prefix_pos_next;
                prefix_bad_reg    <= prefix_bad_next;
                seg_open_reg      <= seg_open_next;
                kept_count_reg    <= kept_count_next;
                type_bad_reg      <= type_bad_next;
                type_hyph_reg     <= type_hyph_next;
                path_nonempty_reg <= path_nonempty_next;
            end
        end
    end

endmodule

@@ design/ushp_out_stage.sv @@
// result register for one output word
module ushp_out_stage
    import ushp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    take,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign take      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

@@ design/ur_string_header_parser.sv @@
// top level of the ur header parser
// a word taken into the input register is parsed by the step logic and held in the result register
// one character word per cycle while out_stall is low, set by the single parse step
// between the input register and the result register
// reset: rst_n clears all valid flags and the parse state at once
module ur_string_header_parser
    import ushp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       char_in,
    input  logic             is_last,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       lower_char,
    output logic             in_kept_segment,
    output logic [IDX_W-1:0] segment_index,
    output logic             segment_first,
    output logic             done_res,
    output logic             accepted,
    output logic [IDX_W-1:0] seg_total
);

    logic    take;
    logic    item_valid;
    item_t   item;
    result_t res;
    result_t out_res;

    ushp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .is_last    (is_last),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ushp_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (item_valid && take),
        .item    (item),
        .res     (res)
    );

    ushp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res       (res),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign lower_char      = out_res.lower_char;
    assign in_kept_segment = out_res.in_kept_segment;
    assign segment_index   = out_res.segment_index;
    assign segment_first   = out_res.segment_first;
    assign done_res        = out_res.done_res;
    assign accepted        = out_res.accepted;
    assign seg_total       = out_res.seg_total;

endmodule

@@ design/ushp_checker.sv @@
// port-level checks for the ur header parser, bound to the top level
`include "ur_string_header_parser_assert.svh"

module ushp_checker
    import ushp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [7:0]       lower_char,
    input logic             in_kept_segment,
    input logic [IDX_W-1:0] segment_index,
    input logic             segment_first,
    input logic             done_res,
    input logic             accepted,
    input logic [IDX_W-1:0] seg_total
);

    `USHP_ASSERT_NEXT(a_out_hold, clk, rst_n,
                      out_valid && out_stall, out_valid && $stable(lower_char))

    `USHP_ASSERT_NOW(a_verdict_only_last, clk, rst_n,
                     out_valid && !done_res, !accepted && seg_total == '0)

    `USHP_ASSERT_NOW(a_accept_count, clk, rst_n, out_valid && accepted, seg_total != '0)

    `USHP_ASSERT_NOW(a_first_kept, clk, rst_n, out_valid && segment_first, in_kept_segment)

    `USHP_ASSERT_NOW(a_idle_index, clk, rst_n, out_valid && !in_kept_segment, segment_index == '0 && !segment_first)

endmodule

bind ur_string_header_parser ushp_checker u_ushp_checker (.*);

@@ dv/ur_string_header_parser_tb.sv @@
// testbench for the ur header parser: directed and random character strings checked against a parse predictor
`timescale 1ns / 1ps

module ur_string_header_parser_tb;
    import ushp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int RANDOM_WORDS = 450;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [7:0]       char_in   = 8'h00;
    logic             is_last   = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       lower_char;
    logic             in_kept_segment;
    logic [IDX_W-1:0] segment_index;
    logic             segment_first;
    logic             done_res;
    logic             accepted;
    logic [IDX_W-1:0] seg_total;

    typedef struct {
        logic [7:0]  ch;
        logic        is_final;
        int unsigned gap;
        bit          drain_first;
    } char_word_t;

    char_word_t  char_queue[$];
    result_t     expected_results[$];

    int unsigned words_queued = 0;
    bit          drain_next   = 1'b0;
    int unsigned errors       = 0;
    int unsigned cycles       = 0;
    int unsigned results_got  = 0;
    int unsigned wait_count   = 0;
    int unsigned rx_wait      = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          taken        = 1'b0;

    // parse state of the predictor
    int unsigned prefix_seen      = 0;
    bit          prefix_wrong     = 1'b0;
    bit          seg_open         = 1'b0;
    int unsigned segs_kept        = 0;
    bit          type_wrong       = 1'b0;
    bit          type_ends_hyphen = 1'b0;
    bit          path_seen        = 1'b0;

    ur_string_header_parser uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .char_in         (char_in),
        .is_last         (is_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .lower_char      (lower_char),
        .in_kept_segment (in_kept_segment),
        .segment_index   (segment_index),
        .segment_first   (segment_first),
        .done_res        (done_res),
        .accepted        (accepted),
        .seg_total       (seg_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic parse_char(input logic [7:0] raw, input logic is_final, output result_t r);
        logic [7:0] c;
        logic [7:0] want;
        bit         opened;
        bit         ok;
        c = raw;
        r = '0;
        opened = 1'b0;
        if (c >= "A" && c <= "Z")
            c = c + 8'd32;
        if (prefix_seen < PREFIX_LEN)
        begin
            want = (prefix_seen == 0) ? CHAR_U : ((prefix_seen == 1) ? CHAR_R : CHAR_COLON);
            if (c != want)
                prefix_wrong = 1'b1;
            prefix_seen++;
        end
        else
        begin
            path_seen = 1'b1;
            if (c == CHAR_SLASH)
                seg_open = 1'b0;
            else
            begin
                if (!seg_open && segs_kept < SEG_CAP)
                begin
                    seg_open = 1'b1;
                    segs_kept++;
                    opened = 1'b1;
                end
                if (seg_open)
                begin
                    r.in_kept_segment = 1'b1;
                    r.segment_index   = IDX_W'(segs_kept - 1);
                    r.segment_first   = opened;
                    if (segs_kept == 1)
                    begin
                        if (opened && c == CHAR_HYPHEN)
                            type_wrong = 1'b1;
                        if (!((c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
                              c == CHAR_HYPHEN))
                            type_wrong = 1'b1;
                        type_ends_hyphen = (c == CHAR_HYPHEN);
                    end
                end
            end
        end
        r.lower_char = c;
        r.done_res   = is_final;
        if (is_final)
        begin
            ok = prefix_seen >= PREFIX_LEN && !prefix_wrong && path_seen && segs_kept >= 2 &&
                 !type_wrong && !type_ends_hyphen;
            r.accepted  = ok;
            r.seg_total = ok ? IDX_W'(segs_kept - 1) : '0;
            prefix_seen      = 0;
            prefix_wrong     = 1'b0;
            seg_open         = 1'b0;
            segs_kept        = 0;
            type_wrong       = 1'b0;
            type_ends_hyphen = 1'b0;
            path_seen        = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_char(input logic [7:0] c, input logic is_final);
        char_word_t w;
        w.ch          = c;
        w.is_final    = is_final;
        // every third stretch of words runs back to back
        w.gap         = ((words_queued / 80) % 3 == 1) ? 0 : $urandom_range(0, 19);
        w.drain_first = drain_next;
        drain_next    = 1'b0;
        char_queue.push_back(w);
        words_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] type_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 8'(97 + $urandom_range(0, 25));
            5, 6:          return 8'(65 + $urandom_range(0, 25));
            7, 8:          return 8'(48 + $urandom_range(0, 9));
            default:       return CHAR_HYPHEN;
        endcase
    endfunction

    task automatic queue_random_string();
        logic [7:0]  s[$];
        logic [7:0]  c;
        int unsigned kind;
        int unsigned nseg;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8))
                s.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            for (int i = 0; i < PREFIX_LEN; i++)
            begin
                c = (i == 0) ? CHAR_U : ((i == 1) ? CHAR_R : CHAR_COLON);
                if (c != CHAR_COLON && $urandom_range(0, 1) == 1)
                    c = c - 8'd32;
                if ($urandom_range(0, 19) == 0)
                    c = 8'($urandom_range(1, 255));
                s.push_back(c);
            end
            if (kind == 1)
            begin
                // string cut short inside the prefix
                repeat ($urandom_range(1, 2))
                    void'(s.pop_back());
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    s.push_back(CHAR_SLASH);
                nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
                for (int k = 0; k < nseg; k++)
                begin
                    repeat ($urandom_range(1, 5))
                        s.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255))
                                                                 : type_char());
                    if (k < nseg - 1 || $urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 2))
                            s.push_back(CHAR_SLASH);
                end
            end
        end
        for (int i = 0; i < s.size(); i++)
            queue_char(s[i], i == s.size() - 1);
    endtask

    // driver: offers the next queued word after its gap, first waiting for results to drain if marked
    always @(negedge clk)
    begin : drive_words
        char_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || taken)
        begin
            if (char_queue.size() == 0)
                in_valid <= 1'b0;
            else if (char_queue[0].drain_first && expected_results.size() != 0)
                in_valid <= 1'b0;
            else if (wait_count < char_queue[0].gap)
            begin
                wait_count++;
                in_valid <= 1'b0;
            end
            else
            begin
                w = char_queue.pop_front();
                char_in    <= w.ch;
                is_last    <= w.is_final;
                in_valid   <= 1'b1;
                wait_count = 0;
            end
        end
    end

    // receiver stall, with one long hold once results are flowing
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (!hold_done && results_got >= 120)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_valid && rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: predicts accepted words and checks delivered results
    always @(posedge clk)
    begin : watch_results
        result_t want;
        taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_char(char_in, is_last, want);
                expected_results.push_back(want);
                taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                results_got++;
                rx_wait = ((results_got / 60) % 3 == 1) ? 0 : $urandom_range(0, 19);
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("lower_char", want.lower_char, lower_char);
                    compare_field("in_kept_segment", want.in_kept_segment, in_kept_segment);
                    compare_field("segment_index", want.segment_index, segment_index);
                    compare_field("segment_first", want.segment_first, segment_first);
                    compare_field("done_res", want.done_res, done_res);
                    compare_field("accepted", want.accepted, accepted);
                    compare_field("seg_total", want.seg_total, seg_total);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ur_string_header_parser: mismatch");
            $finish;
        end
    end

    initial
    begin
        queue_text("UR:A-1/Z");
        queue_text("u");
        queue_text("uR:\377//-");
        queue_text("ur:a-/b");
        queue_text("ur:a/b/c/d/e/f/g/h/i/j/k");
        drain_next = 1'b1;
        while (words_queued < RANDOM_WORDS)
            queue_random_string();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (errors == 0)
            $display("ur_string_header_parser: match");
        else
            $display("ur_string_header_parser: mismatch");
        $finish;
    end

endmodule

@@ ur_string_header_parser.f @@
+incdir+design
design/ushp_pkg.sv
design/ushp_in_stage.sv
design/ushp_step.sv
design/ushp_out_stage.sv
design/ur_string_header_parser.sv
design/ushp_checker.sv
dv/ur_string_header_parser_tb.sv
